/* design/lsvp_pkg.sv */
// Package for the LIFO stack with value purge.
// Holds the item and result structs, command codes, controller states and
// the controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps

package lsvp_pkg;

	// Default store depth
	localparam int STACK_DEPTH_DEF = 64;

	// Result field widths fixed by the interface
	localparam int COUNT_FIELD_W = 7;
	localparam int DATA_W        = 32;

	// Command codes
	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_POP   = 2'd1;
	localparam logic [1:0] CMD_PURGE = 2'd2;

	// Input item
	typedef struct packed {
		logic [1:0]               cmd;
		logic signed [DATA_W-1:0] value;
	} req_t;

	// Result item
	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] popped_value;
		logic [COUNT_FIELD_W-1:0] removed_count;
		logic                     top_valid;
		logic signed [DATA_W-1:0] top_value;
		logic [COUNT_FIELD_W-1:0] depth;
	} rsp_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_POP,
		ST_POP_LOAD,
		ST_PURGE_INIT,
		ST_PURGE_SCAN,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic latch;       // capture item, clear per-item result fields
		logic push;
		logic pop;
		logic pop_load;    // load new top from store read
		logic purge_init;
		logic purge_step;
		logic done;        // present result
	} dp_ctrl_t;

	// Datapath to controller status
	typedef struct packed {
		logic empty;
		logic scan_last;
	} dp_status_t;

endpackage

/* design/lsvp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the stack entry store. No dependencies.
`timescale 1ns / 1ps

module lsvp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* design/lsvp_ctrl.sv */
// Controller state machine for the LIFO stack with value purge.
// Sequences push, pop and purge on the datapath. Depends on lsvp_pkg.
`timescale 1ns / 1ps

module lsvp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          cmd,
	input  lsvp_pkg::dp_status_t status,
	output lsvp_pkg::dp_ctrl_t  ctrl,
	output logic                busy
);

	lsvp_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsvp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		case (state_q)
			lsvp_pkg::ST_IDLE: begin
				if (start) begin
					ctrl.latch = 1'b1;
					case (cmd)
						lsvp_pkg::CMD_PUSH:  state_d = lsvp_pkg::ST_PUSH;
						lsvp_pkg::CMD_POP:   state_d = lsvp_pkg::ST_POP;
						lsvp_pkg::CMD_PURGE: state_d = lsvp_pkg::ST_PURGE_INIT;
						default:             state_d = lsvp_pkg::ST_DONE;
					endcase
				end
			end
			lsvp_pkg::ST_PUSH: begin
				ctrl.push = 1'b1;
				state_d   = lsvp_pkg::ST_DONE;
			end
			lsvp_pkg::ST_POP: begin
				ctrl.pop = 1'b1;
				state_d  = status.empty ? lsvp_pkg::ST_DONE : lsvp_pkg::ST_POP_LOAD;
			end
			lsvp_pkg::ST_POP_LOAD: begin
				ctrl.pop_load = 1'b1;
				state_d       = lsvp_pkg::ST_DONE;
			end
			lsvp_pkg::ST_PURGE_INIT: begin
				ctrl.purge_init = 1'b1;
				state_d = status.empty ? lsvp_pkg::ST_DONE : lsvp_pkg::ST_PURGE_SCAN;
			end
			lsvp_pkg::ST_PURGE_SCAN: begin
				ctrl.purge_step = 1'b1;
				if (status.scan_last) begin
					state_d = lsvp_pkg::ST_DONE;
				end
			end
			lsvp_pkg::ST_DONE: begin
				ctrl.done = 1'b1;
				state_d   = lsvp_pkg::ST_IDLE;
			end
			default: begin
				state_d = lsvp_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != lsvp_pkg::ST_IDLE);

endmodule

/* design/lsvp_datapath.sv */
// Datapath for the LIFO stack with value purge: entry count, top register,
// purge scan counters and the entry store. Depends on lsvp_pkg, lsvp_ram.
`timescale 1ns / 1ps

module lsvp_datapath #(
	parameter int STACK_DEPTH = lsvp_pkg::STACK_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lsvp_pkg::req_t       req,
	input  lsvp_pkg::dp_ctrl_t   ctrl,
	output lsvp_pkg::dp_status_t status,
	output lsvp_pkg::rsp_t       rsp
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int DW = lsvp_pkg::DATA_W;
	localparam int FW = lsvp_pkg::COUNT_FIELD_W;

	logic [CW-1:0] count_q;
	logic [CW-1:0] chk_q;      // index of the entry whose read data is arriving
	logic [CW-1:0] kept_q;
	logic [CW-1:0] removed_q;
	logic [DW-1:0] value_q;
	logic [DW-1:0] top_q;
	logic [DW-1:0] popped_q;
	logic          ok_q;

	logic          full;
	logic          match;
	logic [CW-1:0] chk_next;
	logic [CW-1:0] pop_rd_idx;
	logic [CW-1:0] kept_next;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [DW-1:0] wr_data;
	logic [AW-1:0] rd_addr;
	logic [DW-1:0] rd_data;

	logic [CW+FW-1:0] count_ext;
	logic [CW+FW-1:0] removed_ext;

	assign full       = (count_q == CW'(STACK_DEPTH));
	assign match      = (rd_data == value_q);
	assign chk_next   = CW'(chk_q + CW'(1));
	assign pop_rd_idx = CW'(count_q - CW'(2));
	assign kept_next  = match ? kept_q : CW'(kept_q + CW'(1));

	assign status.empty     = (count_q == '0);
	assign status.scan_last = (chk_next == count_q);

	// Store write: push at the top, purge compacts survivors downwards
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = value_q;
		if (ctrl.push && !full) begin
			wr_en = 1'b1;
		end else if (ctrl.purge_step && !match) begin
			wr_en   = 1'b1;
			wr_addr = kept_q[AW-1:0];
			wr_data = rd_data;
		end
	end

	// Store read address: new top on pop, next entry during a purge scan
	always_comb begin
		rd_addr = '0;
		if (ctrl.pop) begin
			rd_addr = pop_rd_idx[AW-1:0];
		end else if (ctrl.purge_step) begin
			rd_addr = chk_next[AW-1:0];
		end
	end

	lsvp_ram #(
		.WIDTH(DW),
		.DEPTH(STACK_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Control state: entry count and top register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			top_q   <= '0;
		end else begin
			if (ctrl.push && !full) begin
				count_q <= CW'(count_q + CW'(1));
				top_q   <= value_q;
			end else if (ctrl.pop && !status.empty) begin
				count_q <= CW'(count_q - CW'(1));
			end else if (ctrl.pop_load) begin
				top_q <= (count_q != '0) ? rd_data : '0;
			end else if (ctrl.purge_init) begin
				top_q <= '0;
			end else if (ctrl.purge_step) begin
				if (!match) begin
					top_q <= rd_data;
				end
				if (status.scan_last) begin
					count_q <= kept_next;
				end
			end
		end
	end

	// Per-item result fields and scan counters
	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			value_q   <= req.value;
			ok_q      <= 1'b0;
			popped_q  <= '0;
			removed_q <= '0;
		end
		if (ctrl.push) begin
			ok_q <= !full;
		end
		if (ctrl.pop && !status.empty) begin
			ok_q     <= 1'b1;
			popped_q <= top_q;
		end
		if (ctrl.purge_init) begin
			ok_q   <= 1'b1;
			chk_q  <= '0;
			kept_q <= '0;
		end
		if (ctrl.purge_step) begin
			chk_q  <= chk_next;
			kept_q <= kept_next;
			if (match) begin
				removed_q <= CW'(removed_q + CW'(1));
			end
		end
	end

	// Result: counts masked to the field width
	assign count_ext   = {{FW{1'b0}}, count_q};
	assign removed_ext = {{FW{1'b0}}, removed_q};

	assign rsp.ok            = ok_q;
	assign rsp.popped_value  = popped_q;
	assign rsp.removed_count = removed_ext[FW-1:0];
	assign rsp.top_valid     = (count_q != '0);
	assign rsp.top_value     = top_q;
	assign rsp.depth         = count_ext[FW-1:0];

endmodule

/* design/lifo_stack_with_value_purge.sv */
// Top level of the LIFO stack with value purge.
// Joins the controller (lsvp_ctrl) and the datapath (lsvp_datapath).
// Depends on lsvp_pkg.
//
// Usage:
//   Command channel: req (cmd, value) is transferred at a rising edge with
//   start high and busy low. cmd selects push, pop or purge-by-value; other
//   codes leave the stack alone and report ok low.
//   Result channel: rsp is valid for exactly one cycle while done is high;
//   the receiver cannot stall it and must take it in that cycle.
//   busy stays high from the transfer until the cycle after done.
// Sequence (states from the transfer to the cycle done is high):
//   push PUSH, DONE; pop POP, POP_LOAD, DONE (POP, DONE when empty);
//   unused code DONE; purge PURGE_INIT, then PURGE_SCAN for each of the N
//   entries held before the purge, then DONE (PURGE_INIT, DONE when empty).
//   A new command may be transferred the cycle after done. The scan reads one
//   store entry per cycle through the single read port of the entry RAM.
// Reset: arst_n low empties the stack; store contents are not cleared, and
//   no clearing pass is needed, so commands are taken right after reset.
`timescale 1ns / 1ps

module lifo_stack_with_value_purge #(
	parameter int STACK_DEPTH = lsvp_pkg::STACK_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lsvp_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output lsvp_pkg::rsp_t rsp
);

	lsvp_pkg::dp_ctrl_t   ctrl;
	lsvp_pkg::dp_status_t status;

	lsvp_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (req.cmd),
		.status(status),
		.ctrl  (ctrl),
		.busy  (busy)
	);

	lsvp_datapath #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.ctrl  (ctrl),
		.status(status),
		.rsp   (rsp)
	);

	assign done = ctrl.done;

endmodule

/* tb/tb.sv */
// Self-checking testbench for lifo_stack_with_value_purge.
// Drives push, pop, purge and unused commands through a queue-fed driver and checks
// every result against an in-bench stack predictor. Depends on lsvp_pkg and the design.
`timescale 1ns / 1ps

module tb;
	import lsvp_pkg::*;

	localparam int STACK_DEPTH   = STACK_DEPTH_DEF;
	localparam int RANDOM_ITEMS  = 1350;
	localparam int QUIET_TAIL    = 120;      // final items sent with no idling
	localparam int DRAIN_CYCLES  = STACK_DEPTH + 16;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int MAX_REPORTS   = 50;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		req_t item;
		bit   hold;     // wait for every outstanding result before sending
	} stim_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	// Stimulus and predictor state
	stim_t       cmd_queue[$];
	rsp_t        due_results[$];
	logic [31:0] shadow_entries[STACK_DEPTH];
	int          shadow_depth = 0;
	logic [31:0] value_pool[4];
	bit          hold_next = 1'b0;
	int          items_queued = 0;

	// Driver working variables
	logic        next_start;
	req_t        next_req;
	int          gap_left = 0;

	int          cycle_count = 0;
	int          mismatch_count = 0;
	int          result_count = 0;

	lifo_stack_with_value_purge #(
		.STACK_DEPTH(STACK_DEPTH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stack predictor: applies one command to the shadow stack, returns the result
	function automatic rsp_t apply_command(input req_t cmd_item);
		rsp_t r;
		int   kept;
		int   removed;
		r = '0;
		case (cmd_item.cmd)
			CMD_PUSH: begin
				if (shadow_depth < STACK_DEPTH) begin
					shadow_entries[shadow_depth] = cmd_item.value;
					shadow_depth++;
					r.ok = 1'b1;
				end
			end
			CMD_POP: begin
				if (shadow_depth > 0) begin
					shadow_depth--;
					r.popped_value = shadow_entries[shadow_depth];
					r.ok = 1'b1;
				end
			end
			CMD_PURGE: begin
				// compact survivors downwards, keeping their order
				kept = 0;
				removed = 0;
				for (int i = 0; i < shadow_depth; i++) begin
					if (shadow_entries[i] == cmd_item.value)
						removed++;
					else begin
						shadow_entries[kept] = shadow_entries[i];
						kept++;
					end
				end
				shadow_depth = kept;
				r.removed_count = removed[COUNT_FIELD_W-1:0];
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.top_valid = (shadow_depth > 0);
		r.top_value = (shadow_depth > 0) ? shadow_entries[shadow_depth-1] : '0;
		r.depth     = shadow_depth[COUNT_FIELD_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
				   input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d: %s is %h, expected %h",
				result_count, name, got, want));
	endtask

	task automatic add_item(input logic [1:0] cmd, input logic [31:0] value);
		stim_t s;
		s.item.cmd   = cmd;
		s.item.value = value;
		s.hold       = hold_next;
		hold_next    = 1'b0;
		cmd_queue.push_back(s);
		items_queued++;
	endtask

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return value_pool[$urandom_range(0, 3)];
	endfunction

	// Driver: one transfer per start/busy handshake, random idle bursts between
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
			gap_left = 0;
		end else begin
			next_start = start;
			next_req   = req;
			// transfer taken at this edge
			if (start && !busy) begin
				due_results.push_back(apply_command(req));
				next_start = 1'b0;
			end
			if (!next_start) begin
				if (gap_left > 0)
					gap_left--;
				else if (cmd_queue.size() != 0 &&
					 !(cmd_queue[0].hold && due_results.size() != 0)) begin
					next_req   = cmd_queue[0].item;
					next_start = 1'b1;
					cmd_queue.pop_front();
					if (cmd_queue.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
						gap_left = $urandom_range(1, 9);
				end
			end
			start <= next_start;
			req   <= next_req;
		end
	end

	// Monitor: each done strobe carries one result, compared with the oldest due
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (due_results.size() == 0)
				report_mismatch($sformatf("result %0d arrived with none due",
					result_count));
			else begin
				rsp_t want;
				want = due_results.pop_front();
				check_field("ok",            rsp.ok,            want.ok);
				check_field("popped_value",  rsp.popped_value,  want.popped_value);
				check_field("removed_count", rsp.removed_count, want.removed_count);
				check_field("top_valid",     rsp.top_valid,     want.top_valid);
				check_field("top_value",     rsp.top_value,     want.top_value);
				check_field("depth",         rsp.depth,         want.depth);
			end
			result_count++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int fill_len;
		int seq_len;
		int roll;
		bit single;

		// Directed: empty-stack cases, field extremes, purges mid/top/absent
		add_item(CMD_POP,    32'h0000_0000);
		add_item(CMD_PURGE,  32'h0000_0000);
		add_item(CMD_UNUSED, 32'hFFFF_FFFF);
		add_item(CMD_PUSH,   32'h8000_0000);
		add_item(CMD_PUSH,   32'h7FFF_FFFF);
		add_item(CMD_PUSH,   32'hFFFF_FFFF);
		add_item(CMD_PUSH,   32'h0000_0000);
		add_item(CMD_PUSH,   32'hFFFF_FFFF);
		add_item(CMD_PUSH,   32'h5555_5555);
		add_item(CMD_UNUSED, 32'hAAAA_AAAA);
		add_item(CMD_PURGE,  32'hFFFF_FFFF);
		add_item(CMD_PURGE,  32'h1234_5678);
		hold_next = 1'b1;
		add_item(CMD_POP,    32'hAAAA_AAAA);
		add_item(CMD_PURGE,  32'h0000_0000);
		add_item(CMD_POP,    32'h5555_5555);
		add_item(CMD_POP,    32'h0000_0000);
		add_item(CMD_POP,    32'hFFFF_FFFF);
		add_item(CMD_PUSH,   32'hAAAA_AAAA);
		add_item(CMD_PURGE,  32'hAAAA_AAAA);

		// Random: mostly mixed traffic on a small value pool, with fill/drain runs
		while (items_queued < RANDOM_ITEMS + 19) begin
			for (int k = 0; k < 4; k++)
				value_pool[k] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 7);
			if ($urandom_range(0, 3) == 0)
				value_pool[$urandom_range(0, 3)] =
					$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			if ($urandom_range(0, 9) == 0) begin
				// fill to or past capacity, purge one value (all of it in single-value runs), drain
				single   = $urandom_range(0, 1);
				fill_len = $urandom_range(STACK_DEPTH, STACK_DEPTH + 8);
				repeat (fill_len)
					add_item(CMD_PUSH, single ? value_pool[0] : pick_value());
				add_item(CMD_PURGE, value_pool[0]);
				repeat ($urandom_range(STACK_DEPTH / 2, STACK_DEPTH + 8))
					add_item(CMD_POP, $urandom);
			end else begin
				seq_len = $urandom_range(8, 30);
				repeat (seq_len) begin
					roll = $urandom_range(0, 19);
					if (roll < 9)
						add_item(CMD_PUSH, pick_value());
					else if (roll < 15)
						add_item(CMD_POP, $urandom);
					else if (roll < 19)
						add_item(CMD_PURGE, pick_value());
					else
						add_item(CMD_UNUSED, $urandom);
				end
			end
			if ($urandom_range(0, 7) == 0)
				hold_next = 1'b1;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every item sent and every result back, then a quiet spell
		do
			@(negedge clk);
		while (cmd_queue.size() != 0 || start || due_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (due_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", due_results.size()));
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
